### hdl/damage_rect_tracker_defines.svh
// assertion macros for the damage rectangle tracker
// no dependencies; included by files that carry concurrent checks
`ifndef DAMAGE_RECT_TRACKER_DEFINES_SVH
`define DAMAGE_RECT_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DRT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("damage_rect_tracker: same-cycle check failed");

// next-cycle implication
`define DRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("damage_rect_tracker: next-cycle check failed");

`else

`define DRT_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define DRT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hdl/drt_pkg.sv
// shared types and constants for the damage rectangle tracker
// no dependencies; used by the channel interfaces and the top level
package drt_pkg;

   // item kinds
   localparam logic [2:0] KIND_DAMAGE      = 3'd0;
   localparam logic [2:0] KIND_MARK_FULL   = 3'd1;
   localparam logic [2:0] KIND_SCENE_BEGIN = 3'd2;
   localparam logic [2:0] KIND_PRESENT     = 3'd3;
   localparam logic [2:0] KIND_STATUS      = 3'd4;

   // present modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_RECT = 2'd1;
   localparam logic [1:0] MODE_FULL = 2'd2;

   // csr register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [15:0] FRAME_WIDTH_RESET  = 16'd640;
   localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd480;

   // border grown around every damage rectangle
   localparam logic [31:0] DAMAGE_PAD = 32'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] rect_left;
      logic [31:0] rect_top;
      logic [31:0] rect_width;
      logic [31:0] rect_height;
   } req_type;

   typedef struct packed {
      logic [1:0]  present_mode;
      logic [15:0] out_left;
      logic [15:0] out_top;
      logic [15:0] out_width;
      logic [15:0] out_height;
      logic        full_pending;
      logic        damage_pending;
   } rsp_type;

   // one axis of a padded and clipped rectangle
   typedef struct packed {
      logic [15:0] start;
      logic [15:0] len;
   } span_type;

endpackage

### hdl/drt_req_if.sv
// request channel of the damage rectangle tracker: valid, ready, item
// depends on drt_pkg
interface drt_req_if;
   import drt_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hdl/drt_rsp_if.sv
// response channel of the damage rectangle tracker: valid, ready, result
// depends on drt_pkg
interface drt_rsp_if;
   import drt_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hdl/damage_rect_tracker.sv
// damage rectangle tracker: two-stage pipeline, one result per request
// depends on drt_pkg, drt_req_if, drt_rsp_if and damage_rect_tracker_defines.svh
//
// usage
//   req_if carries one item per transfer: a damage rectangle, mark full,
//   scene begin, present or status query. every item gives exactly one
//   transfer on rsp_if, in order, carrying the present mode, the box for a
//   rect present and the pending flags after the item.
//   csr_we/csr_index/csr_wdata write frame width (index 0) and frame height
//   (index 1); other indexes are dropped. write only while the block is idle.
// timing
//   a request is registered in stage 1, then in the result register. one item
//   per cycle sustained while rsp ready is high: stage 1 pads and clips the
//   rectangle, stage 2 merges it into the box register.
// reset
//   synchronous reset empties both stages, clears the box and the full flag
//   and loads frame size 640 x 480.
// stall
//   when the receiver holds rsp ready low both stages freeze; one more item
//   still enters stage 1 if it is empty, then req ready drops.
`include "damage_rect_tracker_defines.svh"

module damage_rect_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   drt_req_if.sink                              req_if,
   drt_rsp_if.source                            rsp_if,
   input  logic                                 csr_we,
   input  logic [drt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [15:0]                          csr_wdata
);
   import drt_pkg::*;

   // pad by DAMAGE_PAD on each side (pulled to zero at the origin edge),
   // saturate at 32 bits, then clip to [0, lim)
   function automatic span_type pad_clip(logic [31:0] org, logic [31:0] len,
                                         logic [15:0] lim);
      logic [31:0] base;
      logic [32:0] sum;
      logic [31:0] grown;
      logic [31:0] room;
      span_type    s;
      if (org >= DAMAGE_PAD) begin
         base = org - DAMAGE_PAD;
         sum  = {1'b0, len} + {DAMAGE_PAD, 1'b0};
      end else begin
         base = '0;
         sum  = {1'b0, len} + {1'b0, org} + {1'b0, DAMAGE_PAD};
      end
      grown = sum[32] ? '1 : sum[31:0];
      if (base >= {16'd0, lim}) begin
         room = '0;
      end else begin
         room = {16'd0, lim} - base;
      end
      s.start = base[15:0];
      s.len   = (grown > room) ? room[15:0] : grown[15:0];
      return s;
   endfunction

   // configuration registers
   logic [15:0] frame_width_ff, frame_height_ff;

   // stage 1: padded and clipped rectangle
   logic        s1_valid_ff;
   logic [2:0]  s1_kind_ff;
   logic        s1_hit_ff;       // damage survives empty and clip checks
   logic [15:0] s1_left_ff, s1_top_ff, s1_width_ff, s1_height_ff;

   // tracked state
   logic        box_valid_ff, box_valid_in;
   logic        full_ff, full_in;
   logic [15:0] box_left_ff, box_left_in;
   logic [15:0] box_top_ff, box_top_in;
   logic [16:0] box_width_ff, box_width_in;
   logic [16:0] box_height_ff, box_height_in;

   // result register
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        advance;
   span_type    span_x, span_y;
   logic        hit;

   // whole pipeline moves when the result register is free or being taken
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || advance;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1 logic
   always_comb begin
      span_x = pad_clip(req_if.payload.rect_left, req_if.payload.rect_width,
                        frame_width_ff);
      span_y = pad_clip(req_if.payload.rect_top, req_if.payload.rect_height,
                        frame_height_ff);
      // empty input rect, zero frame, or clipped away
      hit = (req_if.payload.rect_width != '0) && (req_if.payload.rect_height != '0)
            && (span_x.len != '0) && (span_y.len != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_kind_ff   <= req_if.payload.kind;
         s1_hit_ff    <= hit;
         s1_left_ff   <= span_x.start;
         s1_width_ff  <= span_x.len;
         s1_top_ff    <= span_y.start;
         s1_height_ff <= span_y.len;
      end
   end

   // stage 2: merge, flag updates and result
   logic [16:0] new_right, new_bottom;
   logic [17:0] box_right, box_bottom;
   logic [17:0] max_right, max_bottom;
   logic [15:0] min_left, min_top;

   always_comb begin
      // edge sums are 17 and 18 bits wide, so they never overflow
      new_right  = {1'b0, s1_left_ff} + {1'b0, s1_width_ff};
      new_bottom = {1'b0, s1_top_ff} + {1'b0, s1_height_ff};
      box_right  = {2'b0, box_left_ff} + {1'b0, box_width_ff};
      box_bottom = {2'b0, box_top_ff} + {1'b0, box_height_ff};
      min_left   = (s1_left_ff < box_left_ff) ? s1_left_ff : box_left_ff;
      min_top    = (s1_top_ff < box_top_ff) ? s1_top_ff : box_top_ff;
      max_right  = ({1'b0, new_right} > box_right) ? {1'b0, new_right} : box_right;
      max_bottom = ({1'b0, new_bottom} > box_bottom) ? {1'b0, new_bottom} : box_bottom;

      box_valid_in  = box_valid_ff;
      full_in       = full_ff;
      box_left_in   = box_left_ff;
      box_top_in    = box_top_ff;
      box_width_in  = box_width_ff;
      box_height_in = box_height_ff;

      rsp_in.present_mode = MODE_NONE;
      rsp_in.out_left     = '0;
      rsp_in.out_top      = '0;
      rsp_in.out_width    = '0;
      rsp_in.out_height   = '0;

      case (s1_kind_ff)
         KIND_DAMAGE: begin
            if (s1_hit_ff) begin
               box_valid_in = 1'b1;
               if (!box_valid_ff) begin
                  box_left_in   = s1_left_ff;
                  box_top_in    = s1_top_ff;
                  box_width_in  = {1'b0, s1_width_ff};
                  box_height_in = {1'b0, s1_height_ff};
               end else begin
                  // union, span kept to 17 bits
                  box_left_in   = min_left;
                  box_top_in    = min_top;
                  box_width_in  = 17'(max_right - {2'b0, min_left});
                  box_height_in = 17'(max_bottom - {2'b0, min_top});
               end
            end
         end
         KIND_MARK_FULL: begin
            full_in = 1'b1;
         end
         KIND_SCENE_BEGIN: begin
            full_in      = 1'b1;
            box_valid_in = 1'b0;
         end
         KIND_PRESENT: begin
            if (full_ff) begin
               rsp_in.present_mode = MODE_FULL;
            end else if (box_valid_ff) begin
               rsp_in.present_mode = MODE_RECT;
               rsp_in.out_left     = box_left_ff;
               rsp_in.out_top      = box_top_ff;
               rsp_in.out_width    = box_width_ff[15:0];
               rsp_in.out_height   = box_height_ff[15:0];
            end
            full_in      = 1'b0;
            box_valid_in = 1'b0;
         end
         default: ;  // status query and unused kinds change nothing
      endcase

      rsp_in.full_pending   = full_in;
      rsp_in.damage_pending = full_in || box_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_valid_ff <= 1'b0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            box_valid_ff <= box_valid_in;
            full_ff      <= full_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         box_left_ff   <= box_left_in;
         box_top_ff    <= box_top_in;
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
         rsp_ff        <= rsp_in;
      end
   end

   // checks

   // any present that reports something leaves nothing pending
   `DRT_ASSERT_IMPLY(a_present_clears, clock, reset,
      rsp_valid_ff && (rsp_ff.present_mode != MODE_NONE),
      !rsp_ff.full_pending && !rsp_ff.damage_pending)

   // scene begin drops the box and raises the full flag
   `DRT_ASSERT_NEXT(a_scene_begin, clock, reset,
      advance && s1_valid_ff && (s1_kind_ff == KIND_SCENE_BEGIN),
      full_ff && !box_valid_ff)

   // first damage into an empty box takes the clipped rectangle as is
   `DRT_ASSERT_NEXT(a_first_damage, clock, reset,
      advance && s1_valid_ff && (s1_kind_ff == KIND_DAMAGE) && s1_hit_ff && !box_valid_ff,
      box_valid_ff && (box_left_ff == $past(s1_left_ff)) && (box_top_ff == $past(s1_top_ff)))

endmodule

### test/testbench.sv
// self-checking testbench for damage_rect_tracker: directed table, then random phases
// depends on drt_pkg, drt_req_if, drt_rsp_if and the damage_rect_tracker rtl
// every result is compared field by field with the predictor or a fixed row's want
module testbench;
   import drt_pkg::*;

   localparam int unsigned RESET_CYCLES = 7;
   localparam int unsigned PHASES = 8;
   localparam int unsigned ITEMS_PER_PHASE = 125;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned MAX_REPORTS = 100;

   // kinds above status query behave like a status query
   localparam logic [2:0] KIND_RESERVED_LO  = 3'd5;
   localparam logic [2:0] KIND_RESERVED_MID = 3'd6;
   localparam logic [2:0] KIND_RESERVED_HI  = 3'd7;

   // csr indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_HI = 2'd3;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // results that can be read straight off the spec
   localparam rsp_type IDLE_RSP = '0;
   localparam rsp_type FLAGGED_RSP =
      '{MODE_NONE, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1};
   localparam rsp_type FULL_PRESENT_RSP =
      '{MODE_FULL, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0};
   localparam rsp_type WHOLE_FRAME_RSP =
      '{MODE_RECT, 16'd0, 16'd0, 16'd640, 16'd480, 1'b0, 1'b0};

   // one row of the directed table; want only counts where fixed is set
   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] w;
      logic [31:0] h;
      logic        fixed;
      rsp_type     want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [15:0]            csr_wdata;

   drt_req_if req_if ();
   drt_rsp_if rsp_if ();

   damage_rect_tracker uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // predictor state: frame size, bounding box and full redraw flag
   // ---------------------------------------------------------------
   logic [15:0] frame_w;
   logic [15:0] frame_h;
   logic        box_held;
   logic [31:0] box_x;
   logic [31:0] box_y;
   logic [31:0] box_w;
   logic [31:0] box_h;
   logic        full_redraw;

   rsp_type     pending_reports [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          hold_go = 1'b0;
   logic        hold_active = 1'b0;

   // directed table, frame at its reset size of 640 x 480
   stim_row_type directed_rows [0:26] = '{
      // status and present right after reset: nothing pending
      '{KIND_STATUS,  32'd0, 32'd0, 32'd0, 32'd0, 1'b1, IDLE_RSP},
      '{KIND_PRESENT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, IDLE_RSP},
      // plain damage, then present it
      '{KIND_DAMAGE,  32'd10, 32'd20, 32'd30, 32'd40, 1'b0, IDLE_RSP},
      '{KIND_STATUS,  32'd0, 32'd0, 32'd0, 32'd0, 1'b0, IDLE_RSP},
      '{KIND_PRESENT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, IDLE_RSP},
      // empty width or height leaves nothing behind
      '{KIND_DAMAGE,  32'd100, 32'd100, 32'd0, 32'd50, 1'b0, IDLE_RSP},
      '{KIND_DAMAGE,  32'd100, 32'd100, 32'd50, 32'd0, 1'b0, IDLE_RSP},
      '{KIND_PRESENT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, IDLE_RSP},
      // origin inside the pad pulls back to zero, then a merge
      '{KIND_DAMAGE,  32'd0, 32'd1, 32'd5, 32'd5, 1'b0, IDLE_RSP},
      '{KIND_DAMAGE,  32'd1, 32'd0, 32'd7, 32'd3, 1'b0, IDLE_RSP},
      // all ones origin lies beyond the frame
      '{KIND_DAMAGE,  ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, IDLE_RSP},
      '{KIND_PRESENT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, IDLE_RSP},
      // saturating size clips to the whole frame
      '{KIND_DAMAGE,  32'd0, 32'd0, ALL_ONES, ALL_ONES, 1'b0, IDLE_RSP},
      '{KIND_PRESENT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, WHOLE_FRAME_RSP},
      // clipped at the far corner, then origins just past the edges
      '{KIND_DAMAGE,  32'd639, 32'd479, 32'd1, 32'd1, 1'b0, IDLE_RSP},
      '{KIND_DAMAGE,  32'd642, 32'd100, 32'd10, 32'd10, 1'b0, IDLE_RSP},
      '{KIND_DAMAGE,  32'd100, 32'd482, 32'd10, 32'd10, 1'b0, IDLE_RSP},
      '{KIND_PRESENT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, IDLE_RSP},
      // mark full, then a full present
      '{KIND_MARK_FULL, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, FLAGGED_RSP},
      '{KIND_PRESENT,   32'd0, 32'd0, 32'd0, 32'd0, 1'b1, FULL_PRESENT_RSP},
      // scene begin drops the box and forces a full present
      '{KIND_DAMAGE,  32'd50, 32'd60, 32'd70, 32'd80, 1'b0, IDLE_RSP},
      '{KIND_SCENE_BEGIN, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, FLAGGED_RSP},
      '{KIND_PRESENT, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, FULL_PRESENT_RSP},
      // reserved kinds act as a status query
      '{KIND_RESERVED_LO,  ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, IDLE_RSP},
      '{KIND_RESERVED_MID, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, IDLE_RSP},
      '{KIND_RESERVED_HI,  32'd1, 32'd1, 32'd1, 32'd1, 1'b1, IDLE_RSP},
      '{KIND_STATUS,  ALL_ONES, 32'd0, ALL_ONES, 32'd0, 1'b1, IDLE_RSP}
   };

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------
   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? ALL_ONES : sum[31:0];
   endfunction

   // length of a span after cutting it at the frame edge
   function automatic logic [31:0] edge_cut_len(input logic [31:0] start,
                                                input logic [31:0] len,
                                                input logic [31:0] lim);
      if (start >= lim) return 32'd0;
      if (len > lim - start) return lim - start;
      return len;
   endfunction

   function automatic void merge_box(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] w, input logic [31:0] h);
      logic [31:0] right, bottom, box_right, box_bottom;
      if (!box_held) begin
         box_x = x;
         box_y = y;
         box_w = w;
         box_h = h;
         box_held = 1'b1;
         return;
      end
      right = sat_add(x, w);
      bottom = sat_add(y, h);
      box_right = sat_add(box_x, box_w);
      box_bottom = sat_add(box_y, box_h);
      if (x < box_x) box_x = x;
      if (y < box_y) box_y = y;
      if (right > box_right) box_right = right;
      if (bottom > box_bottom) box_bottom = bottom;
      // stored box extent is only 17 bits wide
      box_w = {15'd0, box_right[16:0] - box_x[16:0]};
      box_h = {15'd0, box_bottom[16:0] - box_y[16:0]};
   endfunction

   // pad, pull back at the left and top, clip, then merge
   function automatic void add_damage(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] w, input logic [31:0] h);
      if (w == 0 || h == 0 || frame_w == 0 || frame_h == 0) return;
      if (x >= DAMAGE_PAD) begin
         x = x - DAMAGE_PAD;
         w = sat_add(w, DAMAGE_PAD);
      end else begin
         w = sat_add(w, x);
         x = 32'd0;
      end
      if (y >= DAMAGE_PAD) begin
         y = y - DAMAGE_PAD;
         h = sat_add(h, DAMAGE_PAD);
      end else begin
         h = sat_add(h, y);
         y = 32'd0;
      end
      w = edge_cut_len(x, sat_add(w, DAMAGE_PAD), {16'd0, frame_w});
      h = edge_cut_len(y, sat_add(h, DAMAGE_PAD), {16'd0, frame_h});
      if (w == 0 || h == 0) return;
      merge_box(x, y, w, h);
   endfunction

   // advance the tracker state by one item and return its report
   function automatic rsp_type damage_report_for(input req_type it);
      rsp_type rpt;
      rpt = '0;
      case (it.kind)
         KIND_DAMAGE: add_damage(it.rect_left, it.rect_top, it.rect_width, it.rect_height);
         KIND_MARK_FULL: full_redraw = 1'b1;
         KIND_SCENE_BEGIN: begin
            full_redraw = 1'b1;
            box_held = 1'b0;
         end
         KIND_PRESENT: begin
            if (full_redraw) begin
               rpt.present_mode = MODE_FULL;
            end else if (box_held) begin
               rpt.present_mode = MODE_RECT;
               rpt.out_left = box_x[15:0];
               rpt.out_top = box_y[15:0];
               rpt.out_width = box_w[15:0];
               rpt.out_height = box_h[15:0];
            end
            box_held = 1'b0;
            full_redraw = 1'b0;
         end
         default: ;
      endcase
      rpt.full_pending = full_redraw;
      rpt.damage_pending = full_redraw | box_held;
      return rpt;
   endfunction

   // ---------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("mismatch at cycle %0d: %s got %0h, expected %0h",
                  cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_report(input rsp_type got);
      rsp_type want;
      if (pending_reports.size() == 0) begin
         report_mismatch("result transfer with nothing expected, mode",
                         32'(got.present_mode), 32'(MODE_NONE));
         return;
      end
      want = pending_reports.pop_front();
      if (got.present_mode !== want.present_mode)
         report_mismatch("present_mode", 32'(got.present_mode), 32'(want.present_mode));
      if (got.out_left !== want.out_left)
         report_mismatch("out_left", 32'(got.out_left), 32'(want.out_left));
      if (got.out_top !== want.out_top)
         report_mismatch("out_top", 32'(got.out_top), 32'(want.out_top));
      if (got.out_width !== want.out_width)
         report_mismatch("out_width", 32'(got.out_width), 32'(want.out_width));
      if (got.out_height !== want.out_height)
         report_mismatch("out_height", 32'(got.out_height), 32'(want.out_height));
      if (got.full_pending !== want.full_pending)
         report_mismatch("full_pending", 32'(got.full_pending), 32'(want.full_pending));
      if (got.damage_pending !== want.damage_pending)
         report_mismatch("damage_pending", 32'(got.damage_pending),
                         32'(want.damage_pending));
   endtask

   // result side: check every transfer, then pick ready for the next edge
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_report(rsp_if.payload);
         rsp_if.ready <= !hold_active && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // long receiver hold-off: the pipeline fills and req ready drops
   initial begin : rsp_hold_off
      wait (hold_go);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   // offer one item, with random idle gaps in front; valid stays up afterwards
   task automatic send_item(input req_type it, input bit fixed, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= it;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      // transfer done at this edge
      predicted = damage_report_for(it);
      pending_reports.push_back(fixed ? want : predicted);
   endtask

   // one register write per edge; caller drops csr_we afterwards
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) frame_w = data;
      else if (idx == CSR_FRAME_HEIGHT) frame_h = data;
   endtask

   // stop sending and wait until every expected result has come back
   task automatic drain_reports();
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random item: mostly damage sized to the current frame, plus noise
   function automatic req_type random_item();
      req_type     it;
      int unsigned pick;
      int unsigned fw;
      int unsigned fh;
      it.rect_left = $urandom();
      it.rect_top = $urandom();
      it.rect_width = $urandom();
      it.rect_height = $urandom();
      pick = $urandom_range(99);
      if (pick < 58) it.kind = KIND_DAMAGE;
      else if (pick < 70) it.kind = KIND_PRESENT;
      else if (pick < 75) it.kind = KIND_MARK_FULL;
      else if (pick < 80) it.kind = KIND_SCENE_BEGIN;
      else if (pick < 92) it.kind = KIND_STATUS;
      else it.kind = 3'($urandom_range(KIND_RESERVED_HI, KIND_RESERVED_LO));
      if (it.kind == KIND_DAMAGE) begin
         fw = 32'(frame_w);
         fh = 32'(frame_h);
         case ($urandom_range(9))
            0: ; // raw 32-bit noise, origin mostly off screen
            1: begin
               // sizes near the top of the range, saturating adds
               it.rect_left = $urandom_range(fw + 4);
               it.rect_top = $urandom_range(fh + 4);
               it.rect_width = ALL_ONES - $urandom_range(3);
               it.rect_height = ALL_ONES - $urandom_range(3);
            end
            2: begin
               // origin within 3 of the left and top edges, partly inside the pad
               it.rect_left = $urandom_range(3);
               it.rect_top = $urandom_range(3);
               it.rect_width = $urandom_range(9);
               it.rect_height = $urandom_range(9);
            end
            default: begin
               it.rect_left = $urandom_range(fw + 6);
               it.rect_top = $urandom_range(fh + 6);
               it.rect_width = $urandom_range(fw / 2 + 3);
               it.rect_height = $urandom_range(fh / 2 + 3);
            end
         endcase
      end
      return it;
   endfunction

   // frame sizes per phase, extremes included; phase 4 draws random ones
   logic [15:0] phase_frame_w [0:PHASES-1] =
      '{16'd65535, 16'd0, 16'd1, 16'd640, 16'd0, 16'd16, 16'd300, 16'd65535};
   logic [15:0] phase_frame_h [0:PHASES-1] =
      '{16'd65535, 16'd480, 16'd1, 16'd0, 16'd0, 16'd16, 16'd200, 16'd1};

   initial begin : main_sequence
      req_type     it;
      logic [15:0] next_w;
      logic [15:0] next_h;

      // known values on every input from time zero
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_FRAME_WIDTH;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;

      frame_w = FRAME_WIDTH_RESET;
      frame_h = FRAME_HEIGHT_RESET;
      box_held = 1'b0;
      box_x = '0;
      box_y = '0;
      box_w = '0;
      box_h = '0;
      full_redraw = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      foreach (directed_rows[i]) begin
         it.kind = directed_rows[i].kind;
         it.rect_left = directed_rows[i].x;
         it.rect_top = directed_rows[i].y;
         it.rect_width = directed_rows[i].w;
         it.rect_height = directed_rows[i].h;
         send_item(it, directed_rows[i].fixed, directed_rows[i].want);
      end

      // random phases; each starts idle, so the frame size can change
      // while a box is still held from the phase before
      for (int p = 0; p < PHASES; p++) begin
         drain_reports();
         next_w = (p == 4) ? 16'($urandom()) : phase_frame_w[p];
         next_h = (p == 4) ? 16'($urandom()) : phase_frame_h[p];
         write_csr(CSR_FRAME_WIDTH, next_w);
         write_csr(CSR_FRAME_HEIGHT, next_h);
         // writes to unused indexes must leave the frame size alone
         write_csr((p % 2) ? CSR_RESERVED_HI : CSR_RESERVED_LO, 16'($urandom()));
         csr_we <= 1'b0;
         @(posedge clock);

         case (p % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 87;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 87;
            end
            default: begin
               send_idle_pct = 24;
               rsp_stall_pct = 24;
            end
         endcase
         // back-pressure run: receiver holds off while items keep coming
         if (p == 0) hold_go = 1'b1;

         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_item(random_item(), 1'b0, IDLE_RSP);
      end

      drain_reports();
      if (mismatch_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
